@@ src/gscw_pkg.sv @@
package gscw_pkg;

  // Grid side; legal range 2 to 256. Coordinates stay 6 bits wide.
  localparam int GRID_SIDE = 64;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = $clog2(CELLS);

  localparam int COORD_W = 6;
  localparam int BOUND_W = 7;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // Bound cap: min(GRID_SIDE, 64).
  localparam logic [BOUND_W-1:0] BOUND_CAP = BOUND_W'((GRID_SIDE < 64) ? GRID_SIDE : 64);
  localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(64);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  // Adding one turns clockwise.
  typedef enum logic [1:0] {
    HEAD_PY = 2'd0,
    HEAD_PX = 2'd1,
    HEAD_NY = 2'd2,
    HEAD_NX = 2'd3
  } heading_t;

  // Map entry: bit 1 blocked, bit 0 visited.
  typedef logic [1:0] cell_t;
  localparam cell_t CELL_FREE    = 2'b00;
  localparam cell_t CELL_VISITED = 2'b01;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_blocked;
    logic               cell_visited;
    logic               use_previous;
    logic [COORD_W-1:0] previous_x;
    logic [COORD_W-1:0] previous_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] position_x;
    logic [COORD_W-1:0] position_y;
    logic               advanced;
    logic               walk_done;
  } out_item_t;

  // Neighbor probe result.
  typedef struct packed {
    logic               hit;
    heading_t           dir;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [ADDR_W-1:0]  addr;
  } probe_t;

  function automatic logic [BOUND_W-1:0] bound_of(input logic [BOUND_W-1:0] r);
    return (r > BOUND_CAP) ? BOUND_CAP : r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(GRID_SIDE)) + ADDR_W'(x);
  endfunction

endpackage

@@ src/gscw_if.sv @@
interface gscw_in_if import gscw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gscw_out_if import gscw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/grid_spiral_coverage_walker.sv @@
// Spiral coverage walker over a GRID_SIDE x GRID_SIDE occupancy grid.
// items (sink): one beat per operation. Write stores the blocked and
//   visited bits of one cell, start places the walker and sets its first
//   heading, step probes up to four neighbors clockwise from the heading.
// results (source): exactly one beat per item, walker position plus
//   advanced / walk_done flags.
// cfg_we / cfg_index / cfg_data: column and row bounds, write only; change
//   them only while no item is in flight.
// Timing: a write or start item goes straight to S_DONE, which loads the
//   result register; the block is ready again once S_DONE is left. A step
//   spends a probe state (map read) and a check state (check and
//   visited-bit write) on each in-bounds neighbor and only a probe state on
//   each out-of-bounds one; no new item is taken until its result is loaded.
// Reset: the maps are cleared one cell per cycle, all GRID_SIDE*GRID_SIDE
//   cells (4096 at the default size); items.ready stays low during that
//   pass. Bounds reset to 64, walker to (0,0), heading +y, idle.
// Stall: the result sits in an output register; the block keeps taking
//   items, and only holds its finished result when the register is full.
module grid_spiral_coverage_walker import gscw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  gscw_in_if.sink              items,
  gscw_out_if.source           results
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PROBE = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  // config
  logic [BOUND_W-1:0] grid_columns;
  logic [BOUND_W-1:0] grid_rows;

  // walker
  logic [COORD_W-1:0] walker_x;
  logic [COORD_W-1:0] walker_y;
  heading_t           heading;
  logic               walk_active;
  logic [2:0]         trial;       // 0..3 probe, 4 = all tried
  logic               advanced;
  logic               walk_done;

  logic [ADDR_W-1:0]  clr_addr;

  // map port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  cell_t              ram_wdata;
  logic               ram_re;
  cell_t              ram_rdata;

  probe_t             probe;
  logic               accept;
  logic               write_in_map;
  heading_t           start_heading;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;

  assign write_in_map = (int'(items.data.cell_x) < GRID_SIDE)
                     && (int'(items.data.cell_y) < GRID_SIDE);

  gscw_probe u_probe (
    .x       (walker_x),
    .y       (walker_y),
    .heading (heading),
    .trial   (trial[1:0]),
    .cols    (bound_of(grid_columns)),
    .rows    (bound_of(grid_rows)),
    .probe   (probe)
  );

  gscw_map_ram u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (probe.addr),
    .rdata (ram_rdata)
  );

  // First heading: last move turned counter-clockwise; +y if the previous
  // node is unused or not one axis step away.
  always_comb begin
    logic [BOUND_W-1:0] cx;
    logic [BOUND_W-1:0] cy;
    logic [BOUND_W-1:0] px;
    logic [BOUND_W-1:0] py;
    cx = {1'b0, items.data.cell_x};
    cy = {1'b0, items.data.cell_y};
    px = {1'b0, items.data.previous_x};
    py = {1'b0, items.data.previous_y};
    start_heading = HEAD_PY;
    if (items.data.use_previous) begin
      if (cy == py && cx == px + BOUND_W'(1)) begin
        start_heading = HEAD_PY;     // moved +x
      end else if (cy == py && cx + BOUND_W'(1) == px) begin
        start_heading = HEAD_NY;     // moved -x
      end else if (cx == px && cy == py + BOUND_W'(1)) begin
        start_heading = HEAD_NX;     // moved +y
      end else if (cx == px && cy + BOUND_W'(1) == py) begin
        start_heading = HEAD_PX;     // moved -y
      end
    end
  end

  // Map write mux: clearing pass, cell writes, visited marking.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = probe.addr;
    ram_wdata = CELL_VISITED;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = CELL_FREE;
      end
      S_IDLE: begin
        ram_we    = accept && (items.data.operation == OP_WRITE) && write_in_map;
        ram_waddr = cell_addr(items.data.cell_x, items.data.cell_y);
        ram_wdata = {items.data.cell_blocked, items.data.cell_visited};
      end
      S_CHECK: begin
        ram_we = (ram_rdata == CELL_FREE);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_re = (state == S_PROBE) && !trial[2] && probe.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      grid_columns  <= BOUND_RESET;
      grid_rows     <= BOUND_RESET;
      walker_x      <= '0;
      walker_y      <= '0;
      heading       <= HEAD_PY;
      walk_active   <= 1'b0;
      trial         <= '0;
      advanced      <= 1'b0;
      walk_done     <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLUMNS: grid_columns <= cfg_data;
          CFG_ROWS:    grid_rows    <= cfg_data;
          default:     ;
        endcase
      end

      // S_DONE reloads the register itself when the beat leaves
      if (results.valid && results.ready && state != S_DONE) begin
        results.valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            advanced <= 1'b0;
            trial    <= '0;
            case (items.data.operation)
              OP_START: begin
                walker_x    <= items.data.cell_x;
                walker_y    <= items.data.cell_y;
                heading     <= start_heading;
                walk_active <= 1'b1;
                walk_done   <= 1'b0;
                state       <= S_DONE;
              end
              OP_STEP: begin
                if (walk_active) begin
                  walk_done <= 1'b0;
                  state     <= S_PROBE;
                end else begin
                  walk_done <= 1'b1;
                  state     <= S_DONE;
                end
              end
              default: begin    // write (handled by map port) or unused code
                walk_done <= 1'b0;
                state     <= S_DONE;
              end
            endcase
          end
        end

        S_PROBE: begin
          if (trial[2]) begin
            // every neighbor tried: walk ends in place
            walk_done   <= 1'b1;
            walk_active <= 1'b0;
            state       <= S_DONE;
          end else if (probe.hit) begin
            state <= S_CHECK;
          end else begin
            trial <= trial + 3'd1;
          end
        end

        S_CHECK: begin
          if (ram_rdata == CELL_FREE) begin
            walker_x <= probe.nx;
            walker_y <= probe.ny;
            heading  <= heading_t'(probe.dir - 2'd1);
            advanced <= 1'b1;
            state    <= S_DONE;
          end else begin
            trial <= trial + 3'd1;
            state <= S_PROBE;
          end
        end

        S_DONE: begin
          if (!results.valid || results.ready) begin
            results.data.position_x <= walker_x;
            results.data.position_y <= walker_y;
            results.data.advanced   <= advanced;
            results.data.walk_done  <= walk_done;
            results.valid           <= 1'b1;
            state                   <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // No item may enter during the clearing pass.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !items.ready)
    else $error("item taken during map clear");

  // Visited marking only ever lands on a cell just read as free.
  a_mark_free_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && ram_we) |-> (ram_rdata == CELL_FREE && $past(ram_re)))
    else $error("visited mark without a free read");

  // A result never both advances and ends the walk.
  a_adv_excl_done: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> !(results.data.advanced && results.data.walk_done))
    else $error("advanced and walk_done both set");

  // Trial counter stays within four probes plus the terminal count.
  a_trial_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (trial <= 3'd4))
    else $error("trial counter out of range");

endmodule

@@ src/gscw_map_ram.sv @@
module gscw_map_ram import gscw_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  cell_t             wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output cell_t             rdata
);

  cell_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/gscw_probe.sv @@
module gscw_probe import gscw_pkg::*; (
  input  logic [COORD_W-1:0] x,
  input  logic [COORD_W-1:0] y,
  input  heading_t           heading,
  input  logic [1:0]         trial,
  input  logic [BOUND_W-1:0] cols,
  input  logic [BOUND_W-1:0] rows,
  output probe_t             probe
);

  heading_t           dir;
  logic [BOUND_W-1:0] nx7;
  logic [BOUND_W-1:0] ny7;
  logic               under;

  always_comb begin
    dir   = heading_t'(heading + trial);
    nx7   = {1'b0, x};
    ny7   = {1'b0, y};
    under = 1'b0;
    case (dir)
      HEAD_PY: ny7 = {1'b0, y} + BOUND_W'(1);
      HEAD_PX: nx7 = {1'b0, x} + BOUND_W'(1);
      HEAD_NY: begin
        under = (y == '0);
        ny7   = {1'b0, y} - BOUND_W'(1);
      end
      HEAD_NX: begin
        under = (x == '0);
        nx7   = {1'b0, x} - BOUND_W'(1);
      end
      default: under = 1'b1;
    endcase
    probe.hit  = !under && (nx7 < cols) && (ny7 < rows);
    probe.dir  = dir;
    probe.nx   = nx7[COORD_W-1:0];
    probe.ny   = ny7[COORD_W-1:0];
    probe.addr = cell_addr(nx7[COORD_W-1:0], ny7[COORD_W-1:0]);
  end

endmodule

@@ tb/sv/grid_spiral_coverage_walker_test.sv @@
`timescale 1ns / 1ps

module grid_spiral_coverage_walker_test;
  import gscw_pkg::*;

  // Code 3 has no meaning in the block; it must behave like a write that
  // touches nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles with no beat on either channel before the run is declared hung.
  // The limit must cover the map clearing pass after reset.
  localparam int STALL_LIMIT = 4 * CELLS + 4000;

  // Random part: one bounds setting per phase, items per phase.
  localparam int PHASES     = 10;
  localparam int PHASE_ITEMS = 190;
  localparam int WALK_CAP   = 120;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  gscw_in_if  item_bus ();
  gscw_out_if result_bus ();

  grid_spiral_coverage_walker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_bus),
    .results   (result_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Walker mirror: maps, position, heading, bounds as the block should
  // hold them after every accepted item beat.
  // ---------------------------------------------------------------------
  bit                 occupied [CELLS];
  bit                 covered  [CELLS];
  logic [COORD_W-1:0] walk_x = '0;
  logic [COORD_W-1:0] walk_y = '0;
  heading_t           walk_heading = HEAD_PY;
  bit                 walker_on = 1'b0;
  logic [CFG_W-1:0]   cols = BOUND_RESET;
  logic [CFG_W-1:0]   rows = BOUND_RESET;

  // Results still owed by the block, oldest first.
  out_item_t pending [$];

  int failures    = 0;
  int sent_items  = 0;
  int phase_end   = 0;
  int src_idle    = 30;
  int snk_idle    = 30;
  int quiet       = 0;

  function automatic int step_x(int d);
    case (heading_t'(2'(d)))
      HEAD_PX: return 1;
      HEAD_NX: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int step_y(int d);
    case (heading_t'(2'(d)))
      HEAD_PY: return 1;
      HEAD_NY: return -1;
      default: return 0;
    endcase
  endfunction

  // Usable extent of a bound register: capped by the grid and by the
  // 6-bit coordinates.
  function automatic int span(logic [CFG_W-1:0] r);
    int s;
    s = r;
    if (s > GRID_SIDE) s = GRID_SIDE;
    if (s > 64) s = 64;
    return s;
  endfunction

  // Apply one item to the mirror and return the result it must produce.
  function automatic out_item_t walk_predict(in_item_t it);
    out_item_t r;
    int        cb, rb, nx, ny, d, t, idx;
    bit        moved, ended, found;
    heading_t  h;
    moved = 1'b0;
    ended = 1'b0;
    case (it.operation)
      OP_WRITE: begin
        if (it.cell_x < GRID_SIDE && it.cell_y < GRID_SIDE) begin
          idx = int'(it.cell_y) * GRID_SIDE + int'(it.cell_x);
          occupied[idx] = it.cell_blocked;
          covered[idx]  = it.cell_visited;
        end
      end
      OP_START: begin
        // heading = last move turned counter-clockwise, +y if the previous
        // node is unused or not one axis step away
        h = HEAD_PY;
        found = 1'b0;
        if (it.use_previous) begin
          for (d = 0; d < 4; d++) begin
            if (!found && int'(it.cell_x) - int'(it.previous_x) == step_x(d) &&
                int'(it.cell_y) - int'(it.previous_y) == step_y(d)) begin
              h = heading_t'(2'((d + 3) % 4));
              found = 1'b1;
            end
          end
        end
        walk_x = it.cell_x;
        walk_y = it.cell_y;
        walk_heading = h;
        walker_on = 1'b1;
      end
      OP_STEP: begin
        ended = 1'b1;
        if (walker_on) begin
          cb = span(cols);
          rb = span(rows);
          for (t = 0; t < 4; t++) begin
            d  = (int'(walk_heading) + t) % 4;
            nx = int'(walk_x) + step_x(d);
            ny = int'(walk_y) + step_y(d);
            if (ended && nx >= 0 && nx < cb && ny >= 0 && ny < rb) begin
              idx = ny * GRID_SIDE + nx;
              if (!occupied[idx] && !covered[idx]) begin
                covered[idx] = 1'b1;
                walk_x = COORD_W'(nx);
                walk_y = COORD_W'(ny);
                walk_heading = heading_t'(2'((d + 3) % 4));
                moved = 1'b1;
                ended = 1'b0;
              end
            end
          end
          if (ended) walker_on = 1'b0;
        end
      end
      default: ;
    endcase
    r.position_x = walk_x;
    r.position_y = walk_y;
    r.advanced   = moved;
    r.walk_done  = ended;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed plan: item rows, some with a hand-written result, and
  // register rows.
  // ---------------------------------------------------------------------
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     reg_value;
    in_item_t             item;
    bit                   typed;
    out_item_t            want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic in_item_t mk(logic [1:0] op, int x, int y, bit b, bit v,
                                  bit up, int px, int py);
    in_item_t it;
    it.operation    = op;
    it.cell_x       = COORD_W'(x);
    it.cell_y       = COORD_W'(y);
    it.cell_blocked = b;
    it.cell_visited = v;
    it.use_previous = up;
    it.previous_x   = COORD_W'(px);
    it.previous_y   = COORD_W'(py);
    return it;
  endfunction

  function automatic out_item_t res(int x, int y, bit a, bit d);
    out_item_t r;
    r.position_x = COORD_W'(x);
    r.position_y = COORD_W'(y);
    r.advanced   = a;
    r.walk_done  = d;
    return r;
  endfunction

  function automatic void put(in_item_t it, bit typed = 1'b0, out_item_t w = '0);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.reg_index = '0;
    row.reg_value = '0;
    row.item   = it;
    row.typed  = typed;
    row.want   = w;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void put_reg(logic [CFG_IDX_W-1:0] idx, int val);
    plan_row_t row;
    row.is_reg    = 1'b1;
    row.reg_index = idx;
    row.reg_value = CFG_W'(val);
    row.item      = '0;
    row.typed     = 1'b0;
    row.want      = '0;
    plan.insert(plan.size(), row);
  endfunction

  // Random item with every field filled, operation forced.
  function automatic in_item_t rand_item(logic [1:0] op);
    in_item_t it;
    it = $bits(in_item_t)'($urandom);
    it.operation = op;
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Item side. One beat per call; the expected result is queued at the
  // accepting edge so the mirror always matches the block's order.
  // ---------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t want = '0);
    out_item_t r;
    while ($urandom_range(99) < src_idle) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.data  <= it;
    do @(posedge clk); while (!item_bus.ready);
    r = walk_predict(it);
    pending.insert(pending.size(), typed ? want : r);
    sent_items++;
  endtask

  // Stop sending and let every owed result drain.
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLUMNS) cols = val;
    else rows = val;
  endtask

  // One well-formed walk: refresh part of the map, start, then step until
  // the walk ends, with some noise beats mixed in.
  task automatic run_walk();
    in_item_t it;
    int       cb, rb, n, d;
    cb = span(cols);
    rb = span(rows);
    if (cb * rb > 0 && cb * rb <= 64 && $urandom_range(2) == 0) begin
      // small grid: rewrite every cell in bounds
      for (int y = 0; y < rb; y++) begin
        for (int x = 0; x < cb; x++) begin
          it = rand_item(OP_WRITE);
          it.cell_x = COORD_W'(x);
          it.cell_y = COORD_W'(y);
          it.cell_blocked = ($urandom_range(99) < 20);
          it.cell_visited = ($urandom_range(99) < 10);
          send_item(it);
        end
      end
    end else begin
      repeat ($urandom_range(10, 2)) begin
        it = rand_item(OP_WRITE);
        if ($urandom_range(9) != 0) begin
          it.cell_x = COORD_W'($urandom_range(cb > 0 ? cb - 1 : 0));
          it.cell_y = COORD_W'($urandom_range(rb > 0 ? rb - 1 : 0));
        end
        it.cell_blocked = ($urandom_range(99) < 20);
        it.cell_visited = ($urandom_range(99) < 15);
        send_item(it);
      end
    end

    it = rand_item(OP_START);
    if ($urandom_range(9) != 0) begin
      it.cell_x = COORD_W'($urandom_range(cb > 0 ? cb - 1 : 0));
      it.cell_y = COORD_W'($urandom_range(rb > 0 ? rb - 1 : 0));
    end
    it.use_previous = ($urandom_range(9) < 8);
    if ($urandom_range(9) < 7) begin
      // previous node one step behind along a random axis
      d = $urandom_range(3);
      it.previous_x = it.cell_x - COORD_W'(step_x(d));
      it.previous_y = it.cell_y - COORD_W'(step_y(d));
    end
    send_item(it);

    n = 0;
    while (walker_on && n < WALK_CAP && sent_items < phase_end) begin
      if ($urandom_range(19) == 0) send_item(rand_item(2'($urandom_range(3))));
      else send_item(rand_item(OP_STEP));
      n++;
    end
    if ($urandom_range(1) == 0) send_item(rand_item(OP_STEP));
    // now and then hold the sender until the result side is empty
    if ($urandom_range(39) == 0) settle();
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure, compare each beat with the oldest
  // expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : take_results
    out_item_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (pending.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: x=%0d y=%0d adv=%0b done=%0b",
                     result_bus.data.position_x, result_bus.data.position_y,
                     result_bus.data.advanced, result_bus.data.walk_done);
        end else begin
          want = pending.pop_front();
          if (result_bus.data.position_x !== want.position_x ||
              result_bus.data.position_y !== want.position_y ||
              result_bus.data.advanced   !== want.advanced ||
              result_bus.data.walk_done  !== want.walk_done) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: got x=%0d y=%0d adv=%0b done=%0b, want x=%0d y=%0d adv=%0b done=%0b",
                       result_bus.data.position_x, result_bus.data.position_y,
                       result_bus.data.advanced, result_bus.data.walk_done,
                       want.position_x, want.position_y, want.advanced, want.walk_done);
          end
        end
      end
      result_bus.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // Hang detector: counts cycles without a beat on either channel.
  always @(posedge clk) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("grid_spiral_coverage_walker_test: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    in_item_t step;
    int       c, r;
    item_bus.valid   = 1'b0;
    item_bus.data    = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;

    step = mk(OP_STEP, 0, 0, 0, 0, 0, 0, 0);

    // after reset: walker idle at origin, maps empty, 64 x 64
    put(step, 1, res(0, 0, 0, 1));                                // step while idle
    put(mk(OP_WRITE, 63, 63, 1, 0, 0, 0, 0), 1, res(0, 0, 0, 0)); // far corner blocked
    put(mk(OP_WRITE, 0, 0, 0, 1, 0, 0, 0), 1, res(0, 0, 0, 0));
    // unused code, every other field all ones
    put(mk(OP_UNUSED, 63, 63, 1, 1, 1, 63, 63), 1, res(0, 0, 0, 0));
    put(mk(OP_START, 0, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0));
    put(step, 1, res(0, 1, 1, 0));                                // +y first
    put(step, 1, res(0, 2, 1, 0));                                // -x off grid, +y again
    // heading from previous node below: last move +y, turn to -x
    put(mk(OP_START, 63, 63, 0, 0, 1, 63, 62), 1, res(63, 63, 0, 0));
    put(step, 1, res(62, 63, 1, 0));
    // previous node two cells away: heading falls back to +y
    put(mk(OP_START, 5, 5, 0, 0, 1, 7, 5), 1, res(5, 5, 0, 0));
    put(step);
    put(mk(OP_START, 10, 10, 0, 0, 1, 11, 10), 1, res(10, 10, 0, 0));
    put(step);
    put(mk(OP_START, 20, 20, 1, 1, 1, 20, 21));
    put(step);
    put(mk(OP_START, 20, 20, 0, 0, 1, 20, 20));                   // previous == start
    put(step);
    put(mk(OP_START, 40, 40, 0, 0, 0, 40, 39));                   // previous ignored
    put(step);
    // boxed-in start: walk ends, then a step on the idle walker
    put(mk(OP_WRITE, 30, 31, 1, 0, 0, 0, 0));
    put(mk(OP_WRITE, 31, 30, 0, 1, 0, 0, 0));
    put(mk(OP_WRITE, 30, 29, 1, 1, 0, 0, 0));
    put(mk(OP_WRITE, 29, 30, 1, 0, 0, 0, 0));
    put(mk(OP_START, 30, 30, 0, 0, 0, 0, 0));
    put(step, 1, res(30, 30, 0, 1));
    put(step, 1, res(30, 30, 0, 1));
    // zero column bound: nothing is in bounds
    put_reg(CFG_COLUMNS, 0);
    put(mk(OP_START, 3, 3, 0, 0, 0, 0, 0));
    put(step, 1, res(3, 3, 0, 1));
    // oversize bounds clamp to the grid
    put_reg(CFG_COLUMNS, 127);
    put_reg(CFG_ROWS, 127);
    put(mk(OP_START, 63, 0, 0, 0, 0, 0, 0));
    put(step);
    put_reg(CFG_COLUMNS, 64);
    put_reg(CFG_ROWS, 64);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // the block clears its maps before it takes the first beat
    do @(posedge clk); while (!item_bus.ready);
    write_reg(CFG_COLUMNS, CFG_W'(64));
    write_reg(CFG_ROWS, CFG_W'(64));

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_index, plan[i].reg_value);
      else send_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    // random walks under a range of bounds; one phase runs with no idling
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin c = 64;  r = 64;  end
        1: begin c = 8;   r = 8;   end
        2: begin c = 5;   r = 3;   end
        3: begin c = 1;   r = 6;   end
        4: begin c = 64;  r = 2;   end
        5: begin c = 127; r = 127; end
        6: begin c = 3;   r = 64;  end
        7: begin c = 0;   r = 5;   end
        default: begin c = $urandom_range(64, 1); r = $urandom_range(16, 1); end
      endcase
      write_reg(CFG_COLUMNS, CFG_W'(c));
      write_reg(CFG_ROWS, CFG_W'(r));
      src_idle  = (p == 4) ? 0 : 30;
      snk_idle  = (p == 4) ? 0 : 30;
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) run_walk();
    end

    settle();
    repeat (16) @(posedge clk);
    if (failures == 0) $display("grid_spiral_coverage_walker_test: clean");
    else $display("grid_spiral_coverage_walker_test: errors");
    $finish;
  end

endmodule
